// ===== hw/rtl/vur_pkg.sv =====
package vur_pkg;

  localparam int SPRITE_BYTES = 256;
  localparam int PATTERN_DEPTH = 8192;
  localparam int NAMETABLE_DEPTH = 2048;
  localparam int PALETTE_DEPTH = 32;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam logic [1:0] OP_READ = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_DMA = 2'd2;
  localparam logic [1:0] OP_TICK = 2'd3;

  localparam logic [2:0] REG_CTRL = 3'd0;
  localparam logic [2:0] REG_MASK = 3'd1;
  localparam logic [2:0] REG_STATUS = 3'd2;
  localparam logic [2:0] REG_SPR_ADDR = 3'd3;
  localparam logic [2:0] REG_SPR_DATA = 3'd4;
  localparam logic [2:0] REG_SCROLL = 3'd5;
  localparam logic [2:0] REG_ADDR = 3'd6;
  localparam logic [2:0] REG_DATA = 3'd7;

  localparam logic [0:0] CFG_MIRRORING = 1'd0;

  localparam logic [8:0] LINE_PRE_RENDER = 9'h1FF;
  localparam logic [8:0] LINE_VBLANK = 9'd241;
  localparam logic [8:0] LINE_LAST = 9'd260;
  localparam logic [8:0] DOT_SHORT = 9'd339;
  localparam logic [8:0] DOT_LAST = 9'd340;

  typedef enum logic [1:0] {
    BUF_ZERO,
    BUF_PAT,
    BUF_NT
  } buf_src_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [2:0] register_select;
    logic [7:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       nmi_request;
    logic       in_vblank;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic advance;
  } pipe_ctl_t;

endpackage

// ===== hw/rtl/vur_ram.sv =====
module vur_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // The read data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/vur_core.sv =====
module vur_core (
  input  logic                clk,
  input  logic                rst_n,
  input  vur_pkg::pipe_ctl_t  ctl,
  input  vur_pkg::in_item_t   item,
  input  logic                nt_mirror_vert,
  output logic                res_valid,
  output vur_pkg::out_item_t  res
);

  logic [14:0]        vram_r, vram_nxt;
  logic [14:0]        tmp_r, tmp_nxt;
  logic               w_r, w_nxt;
  logic [7:0]         latch_r, latch_nxt;
  logic               latch_spr_r, latch_spr_nxt;
  vur_pkg::buf_src_t  buf_src_r, buf_src_nxt;
  logic [7:0]         spr_ptr_r, spr_ptr_nxt;
  logic [7:0]         ctrl_r, ctrl_nxt;
  logic [7:0]         mask_r, mask_nxt;
  logic               vbl_r, vbl_nxt;
  logic               nmi_r, nmi_nxt;
  logic [8:0]         line_r, line_nxt;
  logic [8:0]         dot_r, dot_nxt;
  logic               odd_r, odd_nxt;
  logic [7:0]         pal_r [vur_pkg::PALETTE_DEPTH];

  logic               b_valid_r;
  logic [7:0]         b_data_r;
  logic               b_spr_r;
  logic               b_nmi_r;
  logic               b_vbl_r;

  logic [13:0]        bus_addr;
  logic               is_pat, is_pal;
  logic [10:0]        nt_idx;
  logic [4:0]         pal_idx;
  logic [7:0]         buf_eff, latch_eff;
  logic [14:0]        vram_inc;
  logic [8:0]         line_inc;
  logic               rendering;

  logic               pat_we, pat_re, nt_we, nt_re, spr_we, spr_re, pal_we;
  logic [7:0]         pat_q, nt_q, spr_q;

  always_comb begin
    bus_addr = vram_r[13:0];
    is_pat = !bus_addr[13];
    is_pal = (bus_addr[13:8] == 6'h3F);
    nt_idx = {(nt_mirror_vert ? bus_addr[11] : bus_addr[10]), bus_addr[9:0]};
    pal_idx = bus_addr[4:0];
    if (pal_idx[4] && (pal_idx[1:0] == 2'b00)) begin
      pal_idx[4] = 1'b0;
    end
    case (buf_src_r)
      vur_pkg::BUF_PAT: buf_eff = pat_q;
      vur_pkg::BUF_NT:  buf_eff = nt_q;
      default:          buf_eff = 8'h00;
    endcase
    latch_eff = latch_spr_r ? spr_q : latch_r;
    vram_inc = vram_r + (ctrl_r[2] ? 15'd32 : 15'd1);
    line_inc = line_r + 9'd1;
    rendering = mask_r[4] | mask_r[3];
  end

  always_comb begin
    vram_nxt = vram_r;
    tmp_nxt = tmp_r;
    w_nxt = w_r;
    latch_nxt = latch_r;
    latch_spr_nxt = latch_spr_r;
    buf_src_nxt = buf_src_r;
    spr_ptr_nxt = spr_ptr_r;
    ctrl_nxt = ctrl_r;
    mask_nxt = mask_r;
    vbl_nxt = vbl_r;
    nmi_nxt = nmi_r;
    line_nxt = line_r;
    dot_nxt = dot_r;
    odd_nxt = odd_r;
    pat_we = 1'b0;
    pat_re = 1'b0;
    nt_we = 1'b0;
    nt_re = 1'b0;
    spr_we = 1'b0;
    spr_re = 1'b0;
    pal_we = 1'b0;
    case (item.operation)
      vur_pkg::OP_READ: begin
        latch_spr_nxt = 1'b0;
        unique case (item.register_select)
          vur_pkg::REG_STATUS: begin
            latch_nxt = {vbl_r, 2'b00, latch_eff[4:0]};
            vbl_nxt = 1'b0;
            w_nxt = 1'b0;
          end
          vur_pkg::REG_SPR_DATA: begin
            spr_re = 1'b1;
            latch_spr_nxt = 1'b1;
          end
          vur_pkg::REG_DATA: begin
            vram_nxt = vram_inc;
            if (is_pal) begin
              latch_nxt = {2'b00, pal_r[pal_idx][5:0]};
              nt_re = 1'b1;
              buf_src_nxt = vur_pkg::BUF_NT;
            end else begin
              latch_nxt = buf_eff;
              if (is_pat) begin
                pat_re = 1'b1;
                buf_src_nxt = vur_pkg::BUF_PAT;
              end else begin
                nt_re = 1'b1;
                buf_src_nxt = vur_pkg::BUF_NT;
              end
            end
          end
          default: latch_nxt = latch_eff;
        endcase
      end
      vur_pkg::OP_WRITE: begin
        latch_nxt = item.write_data;
        latch_spr_nxt = 1'b0;
        unique case (item.register_select)
          vur_pkg::REG_CTRL: begin
            ctrl_nxt = item.write_data;
            tmp_nxt[11:10] = item.write_data[1:0];
          end
          vur_pkg::REG_MASK: mask_nxt = item.write_data;
          vur_pkg::REG_SPR_ADDR: spr_ptr_nxt = item.write_data;
          vur_pkg::REG_SPR_DATA: begin
            spr_we = 1'b1;
            spr_ptr_nxt = spr_ptr_r + 8'd1;
          end
          vur_pkg::REG_SCROLL: begin
            if (!w_r) begin
              tmp_nxt[4:0] = item.write_data[7:3];
            end else begin
              tmp_nxt[14:12] = item.write_data[2:0];
              tmp_nxt[9:5] = item.write_data[7:3];
            end
            w_nxt = !w_r;
          end
          vur_pkg::REG_ADDR: begin
            if (!w_r) begin
              tmp_nxt[14:8] = {1'b0, item.write_data[5:0]};
            end else begin
              tmp_nxt[7:0] = item.write_data;
              vram_nxt = {tmp_r[14:8], item.write_data};
            end
            w_nxt = !w_r;
          end
          vur_pkg::REG_DATA: begin
            vram_nxt = vram_inc;
            if (is_pat) begin
              pat_we = 1'b1;
            end else if (is_pal) begin
              pal_we = 1'b1;
            end else begin
              nt_we = 1'b1;
            end
          end
          default: ;
        endcase
      end
      vur_pkg::OP_DMA: begin
        spr_we = 1'b1;
        spr_ptr_nxt = spr_ptr_r + 8'd1;
      end
      default: begin
        if ((line_r == vur_pkg::LINE_VBLANK) && (dot_r == 9'd1)) begin
          vbl_nxt = 1'b1;
          if (ctrl_r[7]) begin
            nmi_nxt = 1'b1;
          end
        end
        if ((line_r == vur_pkg::LINE_PRE_RENDER) && (dot_r == 9'd1)) begin
          vbl_nxt = 1'b0;
          nmi_nxt = 1'b0;
        end
        // On odd frames with rendering on, the pre-render line is one dot short.
        if ((line_r == vur_pkg::LINE_PRE_RENDER) && (dot_r == vur_pkg::DOT_SHORT) &&
            odd_r && rendering) begin
          dot_nxt = 9'd0;
          line_nxt = 9'd0;
        end else if (dot_r >= vur_pkg::DOT_LAST) begin
          dot_nxt = 9'd0;
          if ((line_inc > vur_pkg::LINE_LAST) && (line_inc != vur_pkg::LINE_PRE_RENDER)) begin
            line_nxt = vur_pkg::LINE_PRE_RENDER;
            odd_nxt = !odd_r;
          end else begin
            line_nxt = line_inc;
          end
        end else begin
          dot_nxt = dot_r + 9'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vram_r <= '0;
      tmp_r <= '0;
      w_r <= 1'b0;
      latch_r <= '0;
      latch_spr_r <= 1'b0;
      buf_src_r <= vur_pkg::BUF_ZERO;
      spr_ptr_r <= '0;
      ctrl_r <= '0;
      mask_r <= '0;
      vbl_r <= 1'b0;
      nmi_r <= 1'b0;
      line_r <= vur_pkg::LINE_PRE_RENDER;
      dot_r <= '0;
      odd_r <= 1'b0;
    end else if (ctl.accept) begin
      vram_r <= vram_nxt;
      tmp_r <= tmp_nxt;
      w_r <= w_nxt;
      latch_r <= latch_nxt;
      latch_spr_r <= latch_spr_nxt;
      buf_src_r <= buf_src_nxt;
      spr_ptr_r <= spr_ptr_nxt;
      ctrl_r <= ctrl_nxt;
      mask_r <= mask_nxt;
      vbl_r <= vbl_nxt;
      nmi_r <= nmi_nxt;
      line_r <= line_nxt;
      dot_r <= dot_nxt;
      odd_r <= odd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept && pal_we) begin
      pal_r[pal_idx] <= item.write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (ctl.accept) begin
      b_valid_r <= 1'b1;
    end else if (ctl.advance) begin
      b_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      b_data_r <= latch_nxt;
      b_spr_r <= latch_spr_nxt;
      b_nmi_r <= nmi_nxt;
      b_vbl_r <= vbl_nxt;
    end
  end

  vur_ram #(.DEPTH(vur_pkg::PATTERN_DEPTH), .WIDTH(8)) u_pattern (
    .clk   (clk),
    .we    (ctl.accept && pat_we),
    .waddr (bus_addr[12:0]),
    .wdata (item.write_data),
    .re    (ctl.accept && pat_re),
    .raddr (bus_addr[12:0]),
    .rdata (pat_q)
  );

  vur_ram #(.DEPTH(vur_pkg::NAMETABLE_DEPTH), .WIDTH(8)) u_nametable (
    .clk   (clk),
    .we    (ctl.accept && nt_we),
    .waddr (nt_idx),
    .wdata (item.write_data),
    .re    (ctl.accept && nt_re),
    .raddr (nt_idx),
    .rdata (nt_q)
  );

  vur_ram #(.DEPTH(vur_pkg::SPRITE_BYTES), .WIDTH(8)) u_sprite (
    .clk   (clk),
    .we    (ctl.accept && spr_we),
    .waddr (spr_ptr_r),
    .wdata (item.write_data),
    .re    (ctl.accept && spr_re),
    .raddr (spr_ptr_r),
    .rdata (spr_q)
  );

  assign res_valid = b_valid_r;
  assign res.read_data = b_spr_r ? spr_q : b_data_r;
  assign res.nmi_request = b_nmi_r;
  assign res.in_vblank = b_vbl_r;

endmodule

// ===== hw/rtl/video_unit_register_interface_top.sv =====
// CPU-facing register side of the video unit. Each input transfer is one of
// a register read, a register write, one sprite DMA byte or one dot tick, and
// each yields exactly one result transfer carrying the read or bus-latch
// value, the pending NMI request and the vblank flag after that item.
// Both channels use valid/ready. At its input transfer an item updates the
// register state, loads the result register and starts any memory read, whose
// registered data is ready alongside the result register; the output register
// takes it over when it can advance, so a result passes the result register
// and then the output register. One item is taken every cycle while the
// receiver keeps up, as all the work for an item is a single short pass.
// When the receiver stalls, the output register and the stage behind it hold,
// and input ready drops only once both are full; no result is lost.
// The mirroring register sits on an APB-style port at byte address 0; writes
// take effect at the access phase and should be done while the block is idle.
// Synchronous reset clears the registers, counters and latches, puts the
// scanline counter on the pre-render line and empties the pipeline. The
// pattern, nametable, palette and sprite memories are not cleared.
module video_unit_register_interface_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  vur_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output vur_pkg::out_item_t            out_data,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [vur_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [vur_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [vur_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                          cfg_pready
);

  logic                 mirror_r;
  logic                 out_valid_r;
  vur_pkg::out_item_t   out_data_r;
  logic                 res_valid;
  vur_pkg::out_item_t   res;
  vur_pkg::pipe_ctl_t   ctl;
  logic                 cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                  (cfg_paddr[vur_pkg::CFG_AW-1:2] == vur_pkg::CFG_MIRRORING);
  assign cfg_prdata = (cfg_paddr[vur_pkg::CFG_AW-1:2] == vur_pkg::CFG_MIRRORING) ?
                      {{(vur_pkg::CFG_DW-1){1'b0}}, mirror_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mirror_r <= 1'b0;
    end else if (cfg_wr) begin
      mirror_r <= cfg_pwdata[0];
    end
  end

  assign ctl.advance = !out_valid_r || out_ready;
  assign in_ready = !res_valid || ctl.advance;
  assign ctl.accept = in_valid && in_ready;

  vur_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .item           (in_data),
    .nt_mirror_vert (mirror_r),
    .res_valid      (res_valid),
    .res            (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.advance) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

endmodule

// ===== hw/rtl/vur_checker.sv =====
module vur_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  // A result held back by the receiver stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result transfer dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered straight after reset");

  // After every accepted item, a result is offered once the item could have passed the result and output registers.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> ##1 out_valid)
    else $error("result missing two cycles after input transfer");

  // Input is refused only when the output side is full and stalled.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input refused without an output stall");

endmodule

bind video_unit_register_interface_top vur_checker u_vur_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready)
);
